// ----- rtl/logger_sentence_deframer_unit_defines.svh -----
// Assertion macros shared by the deframer modules.
`ifndef LOGGER_SENTENCE_DEFRAMER_UNIT_DEFINES_SVH
`define LOGGER_SENTENCE_DEFRAMER_UNIT_DEFINES_SVH

// Check a condition at every clock edge out of reset.
`define LSD_ASSERT_NOW(label, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed");

// Check a consequence in the cycle after the trigger.
`define LSD_ASSERT_NEXT(label, trig, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- rtl/lsd_pkg.sv -----
`timescale 1ns / 1ps

package lsd_pkg;

  localparam int unsigned PREFIX_LEN = 7;

  localparam logic [3:0] PH_HUNT    = 4'd0;
  localparam logic [3:0] PH_SEP1    = 4'd1;
  localparam logic [3:0] PH_INDEX   = 4'd2;
  localparam logic [3:0] PH_SEP2    = 4'd3;
  localparam logic [3:0] PH_LEN     = 4'd4;
  localparam logic [3:0] PH_PAYLOAD = 4'd5;
  localparam logic [3:0] PH_STAR    = 4'd6;
  localparam logic [3:0] PH_HEX1    = 4'd7;
  localparam logic [3:0] PH_HEX2    = 4'd8;

  localparam logic [2:0] KIND_PAYLOAD  = 3'd0;
  localparam logic [2:0] KIND_OK       = 3'd1;
  localparam logic [2:0] KIND_CSUM_ERR = 3'd2;
  localparam logic [2:0] KIND_INVALID  = 3'd3;
  localparam logic [2:0] KIND_TOO_MANY = 3'd4;

  localparam logic CFG_RECORD_TYPE = 1'b0;
  localparam logic CFG_MAX_RECORDS = 1'b1;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SIX    = 8'h36;

  localparam logic [7:0] MAX_RECORDS_RESET = 8'd108;

  typedef struct packed {
    logic       valid;
    logic [2:0] kind;
    logic [7:0] payload_byte;
    logic [5:0] record_offset;
    logic       record_end;
    logic [7:0] record_number;
    logic       index_mismatch;
    logic [7:0] sentence_index;
  } lsd_result_t;

  function automatic logic [7:0] prefix_char(input logic [2:0] idx);
    logic [7:0] c;
    unique case (idx)
      3'd0:    c = 8'h24;
      3'd1:    c = 8'h4C;
      3'd2:    c = 8'h4F;
      3'd3:    c = 8'h47;
      3'd4:    c = 8'h31;
      3'd5:    c = 8'h30;
      3'd6:    c = 8'h32;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [5:0] record_size(input logic [2:0] rtype);
    logic [5:0] s;
    unique case (rtype)
      3'd0:    s = 6'd12;
      3'd1:    s = 6'd16;
      3'd2:    s = 6'd20;
      3'd3:    s = 6'd24;
      default: s = 6'd60;
    endcase
    return s;
  endfunction

  // {bad, nibble}
  function automatic logic [4:0] hex_nibble(input logic [7:0] c);
    logic [4:0] r;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b0, 4'(c - 8'h30)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b0, 4'(c - 8'h37)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b0, 4'(c - 8'h57)};
    end else begin
      r = 5'b10000;
    end
    return r;
  endfunction

endpackage

// ----- rtl/lsd_core.sv -----
`timescale 1ns / 1ps
`include "logger_sentence_deframer_unit_defines.svh"

module lsd_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step_en,
  input  logic                mode,
  input  logic [7:0]          data_byte,
  input  logic [2:0]          record_type,
  input  logic [7:0]          max_records,
  output lsd_pkg::lsd_result_t res
);
  import lsd_pkg::*;

  logic [3:0] phase_r, phase_nxt;
  logic [2:0] prefix_r, prefix_nxt;
  logic [7:0] bytes_left_r, bytes_left_nxt;
  logic [7:0] xor_r, xor_nxt;
  logic [7:0] exp_idx_r, exp_idx_nxt;
  logic [7:0] rx_idx_r, rx_idx_nxt;
  logic [5:0] offset_r, offset_nxt;
  logic [7:0] records_r, records_nxt;
  logic [7:0] hex_value_r, hex_value_nxt;
  logic       hex_bad_r, hex_bad_nxt;
  logic       inv_cand_r, inv_cand_nxt;
  logic       mism_r, mism_nxt;

  logic [4:0] nib;
  logic [5:0] rsize;
  logic       rec_end;
  logic       final_bad;
  logic [7:0] final_hex;

  assign nib       = hex_nibble(data_byte);
  assign rsize     = record_size(record_type);
  assign rec_end   = ({1'b0, offset_r} + 7'd1) >= {1'b0, rsize};
  assign final_bad = hex_bad_r | nib[4];
  assign final_hex = nib[4] ? hex_value_r : {hex_value_r[3:0], nib[3:0]};

  always_comb begin
    phase_nxt      = phase_r;
    prefix_nxt     = prefix_r;
    bytes_left_nxt = bytes_left_r;
    xor_nxt        = xor_r;
    exp_idx_nxt    = exp_idx_r;
    rx_idx_nxt     = rx_idx_r;
    offset_nxt     = offset_r;
    records_nxt    = records_r;
    hex_value_nxt  = hex_value_r;
    hex_bad_nxt    = hex_bad_r;
    inv_cand_nxt   = inv_cand_r;
    mism_nxt       = mism_r;
    res            = '0;
    res.sentence_index = rx_idx_r;

    if (step_en) begin
      if (mode) begin
        exp_idx_nxt = 8'd0;
        records_nxt = 8'd0;
        phase_nxt   = PH_HUNT;
        prefix_nxt  = 3'd0;
        xor_nxt     = 8'd0;
      end else begin
        unique case (phase_r)
          PH_HUNT: begin
            if (prefix_r < 3'(PREFIX_LEN) && data_byte == prefix_char(prefix_r)) begin
              xor_nxt = (prefix_r != 3'd0) ? (xor_r ^ data_byte) : 8'd0;
              if (prefix_r == 3'(PREFIX_LEN - 1)) begin
                prefix_nxt = 3'd0;
                phase_nxt  = PH_SEP1;
              end else begin
                prefix_nxt = prefix_r + 3'd1;
              end
            end else begin
              prefix_nxt = (data_byte == CH_DOLLAR) ? 3'd1 : 3'd0;
              xor_nxt    = 8'd0;
            end
          end
          PH_SEP1: begin
            xor_nxt      = xor_r ^ data_byte;
            inv_cand_nxt = (data_byte == CH_COMMA);
            phase_nxt    = PH_INDEX;
          end
          PH_INDEX: begin
            xor_nxt      = xor_r ^ data_byte;
            rx_idx_nxt   = data_byte;
            inv_cand_nxt = inv_cand_r && (data_byte == CH_ZERO);
            phase_nxt    = PH_SEP2;
          end
          PH_SEP2: begin
            xor_nxt      = xor_r ^ data_byte;
            inv_cand_nxt = inv_cand_r && (data_byte == CH_STAR);
            phase_nxt    = PH_LEN;
          end
          PH_LEN: begin
            xor_nxt = xor_r ^ data_byte;
            if (inv_cand_r && data_byte == CH_SIX) begin
              phase_nxt = PH_HUNT;
              res.valid = 1'b1;
              res.kind  = KIND_INVALID;
            end else begin
              mism_nxt       = (rx_idx_r != exp_idx_r);
              exp_idx_nxt    = exp_idx_r + 8'd1;
              bytes_left_nxt = data_byte;
              offset_nxt     = 6'd0;
              phase_nxt      = (data_byte != 8'd0) ? PH_PAYLOAD : PH_STAR;
            end
          end
          PH_PAYLOAD: begin
            if (offset_r == 6'd0 && records_r >= max_records) begin
              phase_nxt          = PH_HUNT;
              res.valid          = 1'b1;
              res.kind           = KIND_TOO_MANY;
              res.record_number  = records_r;
              res.index_mismatch = mism_r;
            end else begin
              if (offset_r == 6'd0) begin
                records_nxt = records_r + 8'd1;
              end
              offset_nxt     = rec_end ? 6'd0 : offset_r + 6'd1;
              xor_nxt        = xor_r ^ data_byte;
              bytes_left_nxt = bytes_left_r - 8'd1;
              if (bytes_left_r == 8'd1) begin
                phase_nxt = PH_STAR;
              end
              res.valid          = 1'b1;
              res.kind           = KIND_PAYLOAD;
              res.payload_byte   = data_byte;
              res.record_offset  = offset_r;
              res.record_end     = rec_end;
              res.record_number  = (offset_r == 6'd0) ? records_r : records_r - 8'd1;
              res.index_mismatch = mism_r;
            end
          end
          PH_STAR: begin
            hex_value_nxt = 8'd0;
            hex_bad_nxt   = 1'b0;
            phase_nxt     = PH_HEX1;
          end
          PH_HEX1: begin
            hex_bad_nxt   = final_bad;
            hex_value_nxt = final_hex;
            phase_nxt     = PH_HEX2;
          end
          PH_HEX2: begin
            hex_bad_nxt        = final_bad;
            hex_value_nxt      = final_hex;
            phase_nxt          = PH_HUNT;
            prefix_nxt         = 3'd0;
            res.valid          = 1'b1;
            res.kind           = (!final_bad && final_hex == xor_r) ? KIND_OK : KIND_CSUM_ERR;
            res.index_mismatch = mism_r;
          end
          default: begin
            phase_nxt  = PH_HUNT;
            prefix_nxt = 3'd0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_HUNT;
      prefix_r     <= 3'd0;
      bytes_left_r <= 8'd0;
      xor_r        <= 8'd0;
      exp_idx_r    <= 8'd0;
      rx_idx_r     <= 8'd0;
      offset_r     <= 6'd0;
      records_r    <= 8'd0;
      hex_value_r  <= 8'd0;
      hex_bad_r    <= 1'b0;
      inv_cand_r   <= 1'b0;
      mism_r       <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      prefix_r     <= prefix_nxt;
      bytes_left_r <= bytes_left_nxt;
      xor_r        <= xor_nxt;
      exp_idx_r    <= exp_idx_nxt;
      rx_idx_r     <= rx_idx_nxt;
      offset_r     <= offset_nxt;
      records_r    <= records_nxt;
      hex_value_r  <= hex_value_nxt;
      hex_bad_r    <= hex_bad_nxt;
      inv_cand_r   <= inv_cand_nxt;
      mism_r       <= mism_nxt;
    end
  end

  `LSD_ASSERT_NEXT(a_start_clears, step_en && mode, phase_r == PH_HUNT && records_r == 8'd0 && exp_idx_r == 8'd0)
  `LSD_ASSERT_NOW(a_offset_in_record, offset_r < 6'd60)
  `LSD_ASSERT_NOW(a_payload_has_bytes, phase_r != PH_PAYLOAD || bytes_left_r != 8'd0)
  `LSD_ASSERT_NOW(a_prefix_bound, prefix_r < 3'(PREFIX_LEN))

endmodule

// ----- rtl/lsd_out_reg.sv -----
`timescale 1ns / 1ps

module lsd_out_reg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  lsd_pkg::lsd_result_t res,
  input  logic                out_tready,
  output logic                out_tvalid,
  output lsd_pkg::lsd_result_t held
);
  import lsd_pkg::*;

  logic        valid_r;
  lsd_result_t data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= res;
    end
  end

  assign out_tvalid = valid_r;
  assign held       = data_r;

endmodule

// ----- rtl/logger_sentence_deframer_unit.sv -----
`timescale 1ns / 1ps
// A request waits in the input register; any result it yields is registered on advance.
// Throughput: one request per cycle; the input register advances whenever the
// result register is empty or being emptied in the same cycle.
// Reset: synchronous, active low; clears the parser state, both registers' valid
// flags and the configuration (record type 0, 108 records).
`include "logger_sentence_deframer_unit_defines.svh"

module logger_sentence_deframer_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tuser,   // [0] mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [7:0] payload_byte, [13:8] record_offset,
                                  // [21:14] record_number, [29:22] sentence_index, [31:30] zero
  output logic [3:0]  out_tuser,  // [2:0] kind, [3] index_mismatch
  output logic        out_tlast,  // record_end
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data
);
  import lsd_pkg::*;

  logic        in_valid_r;
  logic        in_mode_r;
  logic [7:0]  in_byte_r;
  logic [2:0]  record_type_r;
  logic [7:0]  max_records_r;
  logic        advance;
  lsd_result_t res;
  lsd_result_t held;

  assign advance   = in_valid_r && (!out_tvalid || out_tready);
  assign in_tready = !in_valid_r || advance;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_mode_r <= in_tuser;
      in_byte_r <= in_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      record_type_r <= 3'd0;
      max_records_r <= MAX_RECORDS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_RECORD_TYPE: record_type_r <= cfg_data[2:0];
        CFG_MAX_RECORDS: max_records_r <= cfg_data;
        default:         record_type_r <= record_type_r;
      endcase
    end
  end

  lsd_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .step_en     (advance),
    .mode        (in_mode_r),
    .data_byte   (in_byte_r),
    .record_type (record_type_r),
    .max_records (max_records_r),
    .res         (res)
  );

  lsd_out_reg u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (advance && res.valid),
    .res        (res),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .held       (held)
  );

  assign out_tdata = {2'b00, held.sentence_index, held.record_number,
                      held.record_offset, held.payload_byte};
  assign out_tuser = {held.index_mismatch, held.kind};
  assign out_tlast = held.record_end;

  `LSD_ASSERT_NEXT(a_stall_holds_input, in_valid_r && out_tvalid && !out_tready, in_valid_r)
  `LSD_ASSERT_NOW(a_tlast_only_payload, !out_tvalid || !out_tlast || held.kind == KIND_PAYLOAD)
  `LSD_ASSERT_NEXT(a_result_lands, advance && res.valid, out_tvalid)

endmodule
